// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/rls_pkg.sv
// shared constants of the rational linear scaler
`default_nettype none
package rls_pkg;
  localparam int VALUE_BITS  = 64;
  localparam int STATUS_BITS = 2;
  localparam int CFG_BITS    = 32;
  localparam int IDX_BITS    = 3;
  localparam int COEF_REG_BITS = 16;
  localparam int OFFSET_NUM_BITS = 32;

  localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_SAT      = 2'd2;

  localparam logic [IDX_BITS-1:0] REG_SLOPE_POS = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_SLOPE_NUM = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_SLOPE_DEN = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_OFFS_POS  = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_OFFS_NUM  = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_OFFS_DEN  = 3'd5;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_BITS-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;
endpackage
`default_nettype wire

// File: hw/rtl/rational_linear_scaler_unit.sv
// top level of the rational linear scaler
// channel   | ports                               | handshake
// request   | raw_value                           | start, busy
// result    | scaled_value, status                | done, one cycle
// config    | cfg_data, cfg_index                 | cfg_we
// one request a cycle; each request is registered with its product, then passes
// through one divider cell per quotient bit and the output register; busy stays
// low, the cell chain takes a request every cycle
// rst is synchronous and clears the valid chain and the config registers
// results cannot be stalled
`default_nettype none
module rational_linear_scaler_unit #(
  parameter int RAW_BITS  = 32,
  parameter int COEF_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [RAW_BITS-1:0]  raw_value,
  input  wire logic                 cfg_we,
  input  wire logic [rls_pkg::IDX_BITS-1:0] cfg_index,
  input  wire logic [rls_pkg::CFG_BITS-1:0] cfg_data,
  output logic                      done,
  output logic [rls_pkg::VALUE_BITS-1:0]  scaled_value,
  output logic [rls_pkg::STATUS_BITS-1:0] status
);
  import rls_pkg::*;
  localparam int CW  = (COEF_BITS < COEF_REG_BITS) ? COEF_BITS : COEF_REG_BITS;
  localparam int PW  = RAW_BITS + CW;
  localparam int NW  = (PW > OFFSET_NUM_BITS) ? PW : OFFSET_NUM_BITS;
  localparam int DW  = NW + FRAC_BITS;
  localparam int LAT = DW + 2;

  logic                     slope_positive, offset_positive;
  logic [COEF_REG_BITS-1:0] slope_numerator, slope_denominator, offset_denominator;
  logic [OFFSET_NUM_BITS-1:0] offset_numerator;
  logic [CW-1:0]            den_m, den_o;
  logic [PW-1:0]            product;
  logic                     prod_valid;

  logic            valid_c [DW+1];
  logic [CW-1:0]   rem_m_c [DW+1];
  logic [CW-1:0]   rem_o_c [DW+1];
  logic [DW-1:0]   dq_m_c  [DW+1];
  logic [DW-1:0]   dq_o_c  [DW+1];

  assign busy  = 1'b0;
  assign den_m = slope_denominator[CW-1:0];
  assign den_o = offset_denominator[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_positive     <= 1'b1;
      slope_numerator    <= 16'd1;
      slope_denominator  <= 16'd1;
      offset_positive    <= 1'b1;
      offset_numerator   <= '0;
      offset_denominator <= 16'd1;
      prod_valid         <= 1'b0;
    end else begin
      prod_valid <= start && !busy;
      if (cfg_we) begin
        case (cfg_index)
          REG_SLOPE_POS: slope_positive     <= cfg_data[0];
          REG_SLOPE_NUM: slope_numerator    <= cfg_data[COEF_REG_BITS-1:0];
          REG_SLOPE_DEN: slope_denominator  <= cfg_data[COEF_REG_BITS-1:0];
          REG_OFFS_POS:  offset_positive    <= cfg_data[0];
          REG_OFFS_NUM:  offset_numerator   <= cfg_data[OFFSET_NUM_BITS-1:0];
          REG_OFFS_DEN:  offset_denominator <= cfg_data[COEF_REG_BITS-1:0];
          default: ;
        endcase
      end
    end
    product <= PW'(raw_value) * PW'(slope_numerator[CW-1:0]);
  end

  assign valid_c[0] = prod_valid;
  assign rem_m_c[0] = '0;
  assign rem_o_c[0] = '0;
  assign dq_m_c[0]  = DW'(product) << FRAC_BITS;
  assign dq_o_c[0]  = DW'(offset_numerator) << FRAC_BITS;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    rls_div_cell #(.DW(DW), .CW(CW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (valid_c[i]),
      .den_m     (den_m),
      .den_o     (den_o),
      .rem_m_in  (rem_m_c[i]),
      .dq_m_in   (dq_m_c[i]),
      .rem_o_in  (rem_o_c[i]),
      .dq_o_in   (dq_o_c[i]),
      .valid_out (valid_c[i+1]),
      .rem_m_out (rem_m_c[i+1]),
      .dq_m_out  (dq_m_c[i+1]),
      .rem_o_out (rem_o_c[i+1]),
      .dq_o_out  (dq_o_c[i+1])
    );
  end

  rls_combine #(.DW(DW)) u_combine (
    .clk          (clk),
    .rst          (rst),
    .valid_in     (valid_c[DW]),
    .quot_m       (dq_m_c[DW]),
    .quot_o       (dq_o_c[DW]),
    .slope_neg    (!slope_positive),
    .offset_neg   (!offset_positive),
    .zero_den     (den_m == '0 || den_o == '0),
    .done         (done),
    .scaled_value (scaled_value),
    .status       (status)
  );

  `include "assert_macros.svh"
  `ASSERT_IMPLIES(result_has_request, done, $past(start, LAT))
  `ASSERT_IMPLIES(never_busy, start, !busy)
  `ASSERT_NEXT(request_enters_chain, start, prod_valid)
endmodule
`default_nettype wire

// File: hw/rtl/rls_div_cell.sv
// one restoring divider cell, one quotient bit per lane
`default_nettype none
module rls_div_cell #(
  parameter int DW = 64,
  parameter int CW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid_in,
  input  wire logic [CW-1:0] den_m,
  input  wire logic [CW-1:0] den_o,
  input  wire logic [CW-1:0] rem_m_in,
  input  wire logic [DW-1:0] dq_m_in,
  input  wire logic [CW-1:0] rem_o_in,
  input  wire logic [DW-1:0] dq_o_in,
  output logic               valid_out,
  output logic [CW-1:0]      rem_m_out,
  output logic [DW-1:0]      dq_m_out,
  output logic [CW-1:0]      rem_o_out,
  output logic [DW-1:0]      dq_o_out
);
  logic [CW:0] trial_m, trial_o, diff_m, diff_o;
  logic        ge_m, ge_o;

  always_comb begin
    trial_m = {rem_m_in, dq_m_in[DW-1]};
    trial_o = {rem_o_in, dq_o_in[DW-1]};
    diff_m  = trial_m - {1'b0, den_m};
    diff_o  = trial_o - {1'b0, den_o};
    ge_m    = trial_m >= {1'b0, den_m};
    ge_o    = trial_o >= {1'b0, den_o};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    rem_m_out <= ge_m ? diff_m[CW-1:0] : trial_m[CW-1:0];
    rem_o_out <= ge_o ? diff_o[CW-1:0] : trial_o[CW-1:0];
    dq_m_out  <= {dq_m_in[DW-2:0], ge_m};
    dq_o_out  <= {dq_o_in[DW-2:0], ge_o};
  end

  `include "assert_macros.svh"
  `ASSERT_NEXT(cell_valid_follows, valid_in, valid_out)
  `ASSERT_NEXT(cell_no_spurious, !valid_in, !valid_out)
  `ASSERT_NEXT(cell_rem_below_den, valid_in && den_m != '0, rem_m_out < den_m)
endmodule
`default_nettype wire

// File: hw/rtl/rls_combine.sv
// sign application, sum and saturation of the two quotients, zero result on a zero denominator
`default_nettype none
module rls_combine #(
  parameter int DW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid_in,
  input  wire logic [DW-1:0] quot_m,
  input  wire logic [DW-1:0] quot_o,
  input  wire logic          slope_neg,
  input  wire logic          offset_neg,
  input  wire logic          zero_den,
  output logic               done,
  output logic [rls_pkg::VALUE_BITS-1:0]  scaled_value,
  output logic [rls_pkg::STATUS_BITS-1:0] status
);
  import rls_pkg::*;
  localparam int SW = ((DW > VALUE_BITS) ? DW : VALUE_BITS) + 2;

  logic signed [SW-1:0] mag_m, mag_o, term_m, term_o, sum, lim_hi, lim_lo;

  always_comb begin
    mag_m  = signed'(SW'(quot_m));
    mag_o  = signed'(SW'(quot_o));
    term_m = slope_neg ? -mag_m : mag_m;
    term_o = offset_neg ? -mag_o : mag_o;
    sum    = term_m + term_o;
    lim_hi = signed'(SW'(VALUE_MAX));
    lim_lo = signed'({{(SW-VALUE_BITS){1'b1}}, VALUE_MIN});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_in;
    end
    if (zero_den) begin
      scaled_value <= '0;
      status       <= ST_ZERO_DEN;
    end else if (sum > lim_hi) begin
      scaled_value <= VALUE_MAX;
      status       <= ST_SAT;
    end else if (sum < lim_lo) begin
      scaled_value <= VALUE_MIN;
      status       <= ST_SAT;
    end else begin
      scaled_value <= sum[VALUE_BITS-1:0];
      status       <= ST_OK;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPLIES(zero_den_gives_zero, done && status == ST_ZERO_DEN, scaled_value == '0)
  `ASSERT_IMPLIES(sat_at_limits, done && status == ST_SAT,
                  scaled_value == VALUE_MAX || scaled_value == VALUE_MIN)
  `ASSERT_IMPLIES(status_legal, done,
                  status == ST_OK || status == ST_ZERO_DEN || status == ST_SAT)
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// testbench for the rational linear scaler: random and directed requests checked against a predictor
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rls_pkg::*;

  class scale_scoreboard;
    logic [VALUE_BITS-1:0] value_q[$];
    logic [STATUS_BITS-1:0] status_q[$];
    int errors;
    bit slope_pos, offs_pos;
    logic [15:0] slope_num, slope_den, offs_den;
    logic [31:0] offs_num;

    function void clear_regs();
      slope_pos = 1; slope_num = 1; slope_den = 1;
      offs_pos = 1; offs_num = 0; offs_den = 1;
    endfunction

    function void write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] d);
      case (idx)
        REG_SLOPE_POS: slope_pos = d[0];
        REG_SLOPE_NUM: slope_num = d[15:0];
        REG_SLOPE_DEN: slope_den = d[15:0];
        REG_OFFS_POS: offs_pos = d[0];
        REG_OFFS_NUM: offs_num = d;
        REG_OFFS_DEN: offs_den = d[15:0];
        default: ;
      endcase
    endfunction

    function void expect_result(logic [VALUE_BITS-1:0] v, logic [STATUS_BITS-1:0] s);
      value_q.insert(value_q.size(), v);
      status_q.insert(status_q.size(), s);
    endfunction

    function void note_request(logic [31:0] x);
      logic [127:0] sm, om;
      logic [129:0] mag;
      bit neg;
      if (slope_den == 0 || offs_den == 0) begin
        expect_result('0, ST_ZERO_DEN);
        return;
      end
      sm = ({80'd0, x * 48'd1 * slope_num} << 16) / slope_den;
      om = ({96'd0, offs_num} << 16) / offs_den;
      if (slope_pos == offs_pos) begin
        mag = sm + om;
        neg = !slope_pos;
      end else if (sm >= om) begin
        mag = sm - om;
        neg = !slope_pos;
      end else begin
        mag = om - sm;
        neg = !offs_pos;
      end
      if (!neg && mag > 130'h7FFF_FFFF_FFFF_FFFF) begin
        expect_result(VALUE_MAX, ST_SAT);
      end else if (neg && mag > 130'h8000_0000_0000_0000) begin
        expect_result(VALUE_MIN, ST_SAT);
      end else begin
        expect_result(neg ? -mag[63:0] : mag[63:0], ST_OK);
      end
    endfunction

    function void check_result(logic [VALUE_BITS-1:0] v, logic [STATUS_BITS-1:0] s);
      logic [VALUE_BITS-1:0] ev;
      logic [STATUS_BITS-1:0] es;
      if (value_q.size() == 0) begin
        $error("unexpected result scaled_value %h status %0d", v, s);
        errors++;
        return;
      end
      ev = value_q.pop_front();
      es = status_q.pop_front();
      if (v !== ev) begin
        $error("scaled_value expected %h actual %h", ev, v);
        errors++;
      end
      if (s !== es) begin
        $error("status expected %0d actual %0d", es, s);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0, cfg_we = 0, busy, done;
  logic [31:0] raw_value = 0;
  logic [IDX_BITS-1:0] cfg_index = 0;
  logic [CFG_BITS-1:0] cfg_data = 0;
  logic [VALUE_BITS-1:0] scaled_value;
  logic [STATUS_BITS-1:0] status;
  scale_scoreboard sb = new();

  rational_linear_scaler_unit dut (.*);

  initial forever #4 clk = ~clk;

  always @(posedge clk)
    if (!rst && done) sb.check_result(scaled_value, status);

  task automatic send_request(logic [31:0] x, int hold);
    start <= 1;
    raw_value <= x;
    do @(posedge clk); while (busy);
    sb.note_request(x);
    if (hold == 0) start <= 0;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] d);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.value_q.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic random_burst(int n);
    int left, len;
    left = n;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      if (len > left) len = left;
      for (int i = 0; i < len; i++)
        send_request($urandom_range(0, 3) == 0 ? {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0}
                     : $urandom, (i < len - 1) ? 1 : 0);
      left -= len;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  task automatic set_coefs(logic [CFG_BITS-1:0] sp, logic [CFG_BITS-1:0] sn,
                           logic [CFG_BITS-1:0] sd, logic [CFG_BITS-1:0] op,
                           logic [CFG_BITS-1:0] on, logic [CFG_BITS-1:0] od);
    write_reg(REG_SLOPE_POS, sp);
    write_reg(REG_SLOPE_NUM, sn);
    write_reg(REG_SLOPE_DEN, sd);
    write_reg(REG_OFFS_POS, op);
    write_reg(REG_OFFS_NUM, on);
    write_reg(REG_OFFS_DEN, od);
  endtask

  initial begin
    sb.clear_regs();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_request(0, 0);
    send_request(32'hFFFF_FFFF, 0);
    send_request(32'h1234_5678, 0);
    drain();
    set_coefs(1, 32'hFFFF, 1, 1, 32'hFFFF_FFFF, 1);
    send_request(32'hFFFF_FFFF, 1); send_request(1, 0);
    drain();
    set_coefs(0, 32'hFFFF, 1, 0, 32'hFFFF_FFFF, 1);
    send_request(32'hFFFF_FFFF, 1); send_request(0, 0);
    drain();
    set_coefs(0, 3, 7, 1, 5, 3);
    send_request(0, 1); send_request(1, 1); send_request(32'hFFFF_FFFF, 0);
    drain();
    set_coefs(1, 3, 0, 1, 5, 3);
    send_request(7, 0);
    drain();
    write_reg(REG_SLOPE_DEN, 3); write_reg(REG_OFFS_DEN, 0);
    send_request(7, 0);
    drain();
    write_reg(3'd7, 32'hFFFF_FFFF);
    set_coefs(1, 0, 32'hFFFF, 0, 0, 32'hFFFF);
    send_request(32'hFFFF_FFFF, 0);
    drain();
    for (int p = 0; p < 12; p++) begin
      set_coefs($urandom_range(0, 1), $urandom, ($urandom_range(0, 9) == 0) ? 0 : $urandom,
                $urandom_range(0, 1), $urandom, $urandom_range(1, 65535));
      random_burst(50);
      drain();
    end
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/rls_pkg.sv
hw/rtl/rls_div_cell.sv
hw/rtl/rls_combine.sv
hw/rtl/rational_linear_scaler_unit.sv
bench/tb_top.sv
